@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, product bundle type and relation codes for the segment
// intersection test.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int REL_BITS   = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [REL_BITS-1:0] relation_t;

  localparam relation_t REL_DISJOINT = 2'd0;
  localparam relation_t REL_TOUCH    = 2'd1;
  localparam relation_t REL_CROSS    = 2'd2;

  // the four products of one vector pair u, v
  typedef struct packed {
    logic signed [PROD_BITS-1:0] xy;  // u.x * v.y
    logic signed [PROD_BITS-1:0] yx;  // u.y * v.x
    logic signed [PROD_BITS-1:0] xx;  // u.x * v.x
    logic signed [PROD_BITS-1:0] yy;  // u.y * v.y
  } prod_t;

endpackage

`default_nettype wire

@@ rtl/sit_pair_prod.sv @@
// ----------------------------------------------------------------------------
// sit_pair_prod
// Forms u = p - o and v = q - o and the four products needed for the cross
// and dot products of u and v.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_pair_prod (
  input  sit_pkg::coord_t p_x,
  input  sit_pkg::coord_t p_y,
  input  sit_pkg::coord_t q_x,
  input  sit_pkg::coord_t q_y,
  input  sit_pkg::coord_t o_x,
  input  sit_pkg::coord_t o_y,
  output sit_pkg::prod_t  prod
);
  import sit_pkg::*;

  logic signed [DIFF_BITS-1:0] u_x;
  logic signed [DIFF_BITS-1:0] u_y;
  logic signed [DIFF_BITS-1:0] v_x;
  logic signed [DIFF_BITS-1:0] v_y;

  assign u_x = DIFF_BITS'(p_x) - DIFF_BITS'(o_x);
  assign u_y = DIFF_BITS'(p_y) - DIFF_BITS'(o_y);
  assign v_x = DIFF_BITS'(q_x) - DIFF_BITS'(o_x);
  assign v_y = DIFF_BITS'(q_y) - DIFF_BITS'(o_y);

  assign prod.xy = PROD_BITS'(u_x) * PROD_BITS'(v_y);
  assign prod.yx = PROD_BITS'(u_y) * PROD_BITS'(v_x);
  assign prod.xx = PROD_BITS'(u_x) * PROD_BITS'(v_x);
  assign prod.yy = PROD_BITS'(u_y) * PROD_BITS'(v_y);

endmodule

`default_nettype wire

@@ rtl/sit_classify.sv @@
// ----------------------------------------------------------------------------
// sit_classify
// Turns the registered products of the four vector pairs into exact cross
// and dot signs and picks the relation code.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_classify (
  input  sit_pkg::prod_t     prods [4],
  input  logic               kind,
  output sit_pkg::relation_t relation
);
  import sit_pkg::*;

  logic signed [SUM_BITS-1:0] cross_v [4];
  logic signed [SUM_BITS-1:0] dot_v   [4];
  logic [3:0] neg;
  logic [3:0] zero;
  logic [3:0] touch;
  logic       proper;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cross_v[i] = SUM_BITS'($signed(prods[i].xy)) - SUM_BITS'($signed(prods[i].yx));
      dot_v[i]   = SUM_BITS'($signed(prods[i].xx)) + SUM_BITS'($signed(prods[i].yy));
      neg[i]     = cross_v[i][SUM_BITS-1];
      zero[i]    = (cross_v[i] == '0);
      // collinear and between the two ends
      touch[i]   = zero[i] && (dot_v[i][SUM_BITS-1] || (dot_v[i] == '0));
    end
  end

  // both endpoint pairs strictly on opposite sides
  assign proper = !zero[0] && !zero[1] && (neg[0] != neg[1]) &&
                  !zero[2] && !zero[3] && (neg[2] != neg[3]);

  always_comb begin
    if (kind) begin
      // pair 0 is (b - c, a - c): c on segment a-b
      relation = touch[0] ? REL_TOUCH : REL_DISJOINT;
    end else if (proper) begin
      relation = REL_CROSS;
    end else if (|touch) begin
      relation = REL_TOUCH;
    end else begin
      relation = REL_DISJOINT;
    end
  end

endmodule

`default_nettype wire

@@ rtl/segment_intersection_test_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Exact integer test of segment a-b against segment c-d, or of point c
// against segment a-b.
// ----------------------------------------------------------------------------
//  channel | signals                                    | word
//  --------+--------------------------------------------+-------------------
//  in      | in_valid, in_ready, kind, a_x .. d_y       | one query
//  out     | out_valid, out_ready, relation             | one relation code
//
// two register stages: the product register after the subtractors and
// multipliers, and the result register after the sign and classify logic.
// one word per cycle sustained while out_ready is high. a stall on out only
// backs up into the product register; in_ready drops once both stages hold
// words. rst empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  sit_pkg::coord_t    a_x,
  input  sit_pkg::coord_t    a_y,
  input  sit_pkg::coord_t    b_x,
  input  sit_pkg::coord_t    b_y,
  input  sit_pkg::coord_t    c_x,
  input  sit_pkg::coord_t    c_y,
  input  sit_pkg::coord_t    d_x,
  input  sit_pkg::coord_t    d_y,
  output logic               out_valid,
  input  logic               out_ready,
  output sit_pkg::relation_t relation
);
  import sit_pkg::*;

  prod_t     prod_next [4];
  prod_t     prods     [4];
  logic      prod_kind;
  logic      prod_valid;
  logic      prod_ready;
  relation_t relation_next;

  sit_pair_prod u_pair0 (
    .p_x(b_x), .p_y(b_y), .q_x(a_x), .q_y(a_y), .o_x(c_x), .o_y(c_y),
    .prod(prod_next[0])
  );
  sit_pair_prod u_pair1 (
    .p_x(b_x), .p_y(b_y), .q_x(a_x), .q_y(a_y), .o_x(d_x), .o_y(d_y),
    .prod(prod_next[1])
  );
  sit_pair_prod u_pair2 (
    .p_x(d_x), .p_y(d_y), .q_x(c_x), .q_y(c_y), .o_x(a_x), .o_y(a_y),
    .prod(prod_next[2])
  );
  sit_pair_prod u_pair3 (
    .p_x(d_x), .p_y(d_y), .q_x(c_x), .q_y(c_y), .o_x(b_x), .o_y(b_y),
    .prod(prod_next[3])
  );

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prods     <= prod_next;
      prod_kind <= kind;
    end
  end

  sit_classify u_classify (
    .prods(prods),
    .kind(prod_kind),
    .relation(relation_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      relation <= relation_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sit_checker.sv @@
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the segment intersection test core.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               kind,
  input sit_pkg::coord_t    a_x,
  input sit_pkg::coord_t    a_y,
  input sit_pkg::coord_t    b_x,
  input sit_pkg::coord_t    b_y,
  input sit_pkg::coord_t    c_x,
  input sit_pkg::coord_t    c_y,
  input sit_pkg::coord_t    d_x,
  input sit_pkg::coord_t    d_y,
  input logic               out_valid,
  input logic               out_ready,
  input sit_pkg::relation_t relation
);
  import sit_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(relation))
    else $error("result word changed while stalled");

  a_rel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relation == REL_DISJOINT || relation == REL_TOUCH ||
                   relation == REL_CROSS))
    else $error("relation code out of range");

  // a point query, drained without stall, comes out through the product and
  // result registers and never reports a crossing
  a_point_no_cross: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind) ##1 out_ready |=>
      out_valid && relation != REL_CROSS)
    else $error("point query lost or reported as crossing");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (.*);

`default_nettype wire
